/* design/pwl_pkg.sv */
// shared constants, codes and types of the piecewise linear curve interpolator
`default_nettype none
package pwl_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [31:0] Sentinel = 32'd655353446;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } pwl_op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_INTERVAL = 3'd1,
    ST_ZERO_SPAN   = 3'd2,
    ST_FULL        = 3'd3,
    ST_DUPLICATE   = 3'd4
  } pwl_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_FIN
  } pwl_state_e;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] val;
    logic        lt;
    logic        occ;
  } pwl_link_t;

endpackage
`default_nettype wire

/* design/pwl_cell.sv */
// one table cell: holds a point and shifts it up on sorted insertion
`default_nettype none
module pwl_cell
  import pwl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [31:0] x_i,
  input  wire logic [31:0] y_i,
  input  wire logic        ins_i,
  input  wire logic        clr_i,
  input  wire pwl_link_t   prev_i,
  output pwl_link_t        next_o,
  output logic             hit_o,
  output logic             dup_o
);

  logic [31:0] key_q;
  logic [31:0] val_q;
  logic        occ_q;
  logic        lt;

  assign lt     = occ_q & ($signed(key_q) < $signed(x_i));
  assign next_o = '{key: key_q, val: val_q, lt: lt, occ: occ_q};
  assign hit_o  = occ_q & !lt & prev_i.lt;
  assign dup_o  = occ_q & (key_q == x_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else if (clr_i) begin
      occ_q <= 1'b0;
    end else if (ins_i) begin
      occ_q <= occ_q | prev_i.occ;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_i && !lt) begin
      key_q <= prev_i.lt ? x_i : prev_i.key;
      val_q <= prev_i.lt ? y_i : prev_i.val;
    end
  end

endmodule
`default_nettype wire

/* design/pwl_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none
module pwl_div
  import pwl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [32:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quot_o
);

  logic [63:0] dvd_q, dvd_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] dsr_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q;
  logic [33:0] sh;
  logic [34:0] diff;

  assign sh   = {rem_q[32:0], dvd_q[63]};
  assign diff = {1'b0, sh} - {2'b00, dsr_q};

  always_comb begin
    rem_d = diff[34] ? sh : diff[33:0];
    dvd_d = {dvd_q[62:0], ~diff[34]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (run_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule
`default_nettype wire

/* design/piecewise_linear_curve_interpolator.sv */
// top level of the piecewise linear curve interpolator
// Holds up to 16 points sorted by key in a chain of cells. Clear, add and
// unknown-op transactions finish at the accept edge, which loads the result
// register. A query with an interval selects the span at the accept edge, forms
// differences in S_PREP, does the 33x33 multiply in S_MUL, runs the bit-serial
// divider in S_DIV, then adds and saturates in S_FIN. The divider sets the rate.
// A query above the last key or on an empty table returns 9999.9 with status 1
// at the accept edge. No new transaction is taken while a query is in flight.
`default_nettype none
module piecewise_linear_curve_interpolator
  import pwl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] x_value_i,
  input  wire logic [31:0] y_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      result_value_o,
  output logic [2:0]       status_o,
  output logic [4:0]       point_count_o
);

  pwl_state_e state_q, state_d;
  pwl_link_t  links [TableDepth+1];
  logic [TableDepth-1:0] hit, dup;
  logic [CntW-1:0] count_q;
  logic ov_q;
  logic [31:0] res_q;
  logic [2:0]  st_q;
  logic accept, out_free, is_dup, is_full, ins, clr, found;
  logic [31:0] k0, v0, k1, v1;
  logic [31:0] x_q, x0_q, y0_q, x1_q, y1_q;
  logic [32:0] md_q, mdx_q, mdy_q;
  logic        neg_q;
  logic        div_start, div_done;
  logic [63:0] quot;
  logic        quot_hi;
  logic signed [32:0] d, dx, dy;
  logic signed [34:0] qs, sum;
  logic [31:0] sat;
  logic        fin_write;

  assign accept   = in_valid_i & !in_stall_o;
  assign out_free = !ov_q | !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) | !out_free;
  assign is_dup  = |dup;
  assign is_full = count_q >= CntW'(TableDepth);
  assign ins = accept & (pwl_op_e'(op_i) == OP_ADD) & !is_dup & !is_full;
  assign clr = accept & (pwl_op_e'(op_i) == OP_CLEAR);

  assign links[0] = '{key: '0, val: '0, lt: 1'b1, occ: 1'b1};

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    pwl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .x_i    (x_value_i),
      .y_i    (y_value_i),
      .ins_i  (ins),
      .clr_i  (clr),
      .prev_i (links[i]),
      .next_o (links[i+1]),
      .hit_o  (hit[i]),
      .dup_o  (dup[i])
    );
  end

  always_comb begin
    k0 = '0;
    v0 = '0;
    k1 = '0;
    v1 = '0;
    for (int i = 0; i < TableDepth; i++) begin
      k0 = k0 | ({32{hit[i]}} & links[i].key);
      v0 = v0 | ({32{hit[i]}} & links[i].val);
      k1 = k1 | ({32{hit[i]}} & links[i+1].key);
      v1 = v1 | ({32{hit[i]}} & links[i+1].val);
    end
  end
  assign found = |hit;

  assign quot_hi = |quot[63:33];

  always_comb begin
    d  = $signed({x1_q[31], x1_q}) - $signed({x0_q[31], x0_q});
    dx = $signed({x_q[31], x_q}) - $signed({x0_q[31], x0_q});
    dy = $signed({y1_q[31], y1_q}) - $signed({y0_q[31], y0_q});
    qs = neg_q ? -$signed({2'b00, quot[32:0]}) : $signed({2'b00, quot[32:0]});
    sum = $signed({{3{y0_q[31]}}, y0_q}) + qs;
    if (quot_hi) begin
      sat = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (sum > 35'sh0_7FFF_FFFF) begin
      sat = 32'h7FFF_FFFF;
    end else if (sum < -35'sh0_8000_0000) begin
      sat = 32'h8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  assign div_start = (state_q == S_MUL);
  assign fin_write = (state_q == S_FIN) & out_free;

  pwl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (64'(mdy_q * mdx_q)),
    .divisor_i  (md_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && pwl_op_e'(op_i) == OP_QUERY && found && k1 != k0) begin
          state_d = S_PREP;
        end
      end
      S_PREP:  state_d = S_MUL;
      S_MUL:   state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr) begin
        count_q <= '0;
      end else if (ins) begin
        count_q <= count_q + CntW'(1);
      end
      if (accept && !(pwl_op_e'(op_i) == OP_QUERY && found && k1 != k0)) begin
        ov_q <= 1'b1;
      end else if (fin_write) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q  <= x_value_i;
      x0_q <= k0;
      y0_q <= v0;
      x1_q <= k1;
      y1_q <= v1;
      res_q <= '0;
      st_q  <= ST_OK;
      case (pwl_op_e'(op_i))
        OP_ADD: begin
          if (is_dup) begin
            st_q <= ST_DUPLICATE;
          end else if (is_full) begin
            st_q <= ST_FULL;
          end
        end
        OP_QUERY: begin
          if (!found) begin
            res_q <= Sentinel;
            st_q  <= ST_NO_INTERVAL;
          end else if (k1 == k0) begin
            st_q <= ST_ZERO_SPAN;
          end
        end
        default: st_q <= ST_OK;
      endcase
    end
    if (state_q == S_PREP) begin
      neg_q <= dy[32] ^ dx[32] ^ d[32];
      md_q  <= d[32] ? 33'(-d) : 33'(d);
      mdx_q <= dx[32] ? 33'(-dx) : 33'(dx);
      mdy_q <= dy[32] ? 33'(-dy) : 33'(dy);
    end
    if (fin_write) begin
      res_q <= sat;
      st_q  <= ST_OK;
    end
  end

  assign out_valid_o    = ov_q;
  assign result_value_o = res_q;
  assign status_o       = st_q;
  assign point_count_o  = 5'(count_q);

  a_busy_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("input taken while busy");
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth)) else $error("point count above depth");
  a_single_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit)) else $error("more than one span selected");
  a_fin_after_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV)) else $error("divider finished out of turn");

endmodule
`default_nettype wire
